// ===== sv/complementary_orientation_filter_core_macros.svh =====
// Assertion macros for the complementary orientation filter core.
// Included by the top level; no other dependencies.
`ifndef COMPLEMENTARY_ORIENTATION_FILTER_CORE_MACROS_SVH
`define COMPLEMENTARY_ORIENTATION_FILTER_CORE_MACROS_SVH
`ifndef SYNTH
`define COF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define COF_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define COF_ASSERT(lbl, prop, msg)
`define COF_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// ===== sv/cof_pkg.sv =====
// Shared constants, arctangent table and divider handshake types
// for the complementary orientation filter. No dependencies.
package cof_pkg;
    typedef logic [24:0] t_angle;

    localparam logic [24:0] FULL_CIRCLE = 25'd23592960;
    localparam logic [25:0] CIRCLE_W    = 26'd23592960;
    localparam logic [25:0] QUARTER     = 26'd5898240;
    localparam logic [25:0] THREE_Q     = 26'd17694720;
    localparam logic signed [26:0] DEG180 = 27'sd11796480;
    localparam logic signed [26:0] DEG360 = 27'sd23592960;
    localparam logic [6:0]  WEIGHT_MAX  = 7'd100;
    localparam logic [32:0] ACCEL_LIMIT = 33'h0fd70;
    localparam int          CORDIC_STEPS = 24;

    // The full circle is 45 times 2^19, so only the upper bits need a modulo by 45,
    // taken with a reciprocal of 2^28 / 45 rounded up.
    localparam logic [21:0] MOD_DIV   = 22'd45;
    localparam logic [22:0] MOD_RECIP = 23'd5965233;
    // The blend divides by 100 as a shift by two and a reciprocal of 2^36 / 25 rounded up.
    localparam logic [31:0] BLEND_RECIP = 32'd2748779070;

    localparam logic [21:0] ATAN_TAB [CORDIC_STEPS] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117265,
        22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
        22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7,
        22'd4, 22'd2, 22'd1, 22'd1
    };

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [30:0] divisor;
        logic [6:0]  nbits;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
        logic [30:0] rem;
    } t_div_rsp;
endpackage

// ===== sv/cof_cordic.sv =====
// Iterative vectoring CORDIC giving atan2(y, x) in signed Q8.16 degrees, one step per cycle.
// Depends on cof_pkg for the arctangent table and angle constants.
module cof_cordic (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [31:0]  i_y,
    input  logic signed [31:0]  i_x,
    output logic                o_done,
    output logic signed [24:0]  o_angle
);
    import cof_pkg::*;

    logic               r_busy, n_busy;
    logic               r_fin, n_fin;
    logic               r_done, n_done;
    logic [4:0]         r_i, n_i;
    logic signed [35:0] r_x, n_x, r_y, n_y;
    logic signed [26:0] r_z, n_z;
    logic signed [24:0] r_res, n_res;
    logic signed [35:0] xe, ye, dx, dy;
    logic signed [26:0] zn;

    assign xe = 36'(i_x);
    assign ye = 36'(i_y);
    assign dx = r_y >>> r_i;
    assign dy = r_x >>> r_i;

    always_comb begin
        if (r_z > DEG180) begin
            zn = r_z - DEG360;
        end else if (r_z <= -DEG180) begin
            zn = r_z + DEG360;
        end else begin
            zn = r_z;
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_fin  = 1'b0;
        n_done = 1'b0;
        n_i    = r_i;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_res  = r_res;
        if (i_start) begin
            n_i = 5'd0;
            if (i_x == 32'sd0 && i_y == 32'sd0) begin
                n_res  = 25'sd0;
                n_done = 1'b1;
            end else begin
                n_busy = 1'b1;
                if (i_x < 0) begin
                    n_x = -xe;
                    n_y = -ye;
                    n_z = (i_y >= 0) ? DEG180 : -DEG180;
                end else begin
                    n_x = xe;
                    n_y = ye;
                    n_z = 27'sd0;
                end
            end
        end else if (r_busy) begin
            // Once y reaches zero every later step leaves the vector alone.
            if (r_y != 36'sd0) begin
                if (!r_y[35]) begin
                    n_x = r_x + dx;
                    n_y = r_y - dy;
                    n_z = r_z + 27'(ATAN_TAB[r_i]);
                end else begin
                    n_x = r_x - dx;
                    n_y = r_y + dy;
                    n_z = r_z - 27'(ATAN_TAB[r_i]);
                end
            end
            n_i = r_i + 5'd1;
            if (r_i == 5'(CORDIC_STEPS - 1)) begin
                n_busy = 1'b0;
                n_fin  = 1'b1;
            end
        end else if (r_fin) begin
            n_res  = 25'(zn);
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_fin  <= n_fin;
            r_done <= n_done;
        end
        r_i   <= n_i;
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
        r_res <= n_res;
    end

    assign o_done  = r_done;
    assign o_angle = r_res;
endmodule

// ===== sv/cof_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned 64 by 31 bits.
// Depends on cof_pkg for the request and response structs.
module cof_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cof_pkg::t_div_req  i_req,
    output cof_pkg::t_div_rsp  o_rsp
);
    import cof_pkg::*;

    logic        r_busy, r_done;
    logic [6:0]  r_cnt;
    logic [63:0] r_num, r_quot;
    logic [30:0] r_rem, r_div;
    logic [31:0] part, trial;

    assign part  = {r_rem, r_num[63]};
    assign trial = part - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 7'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_req.start) begin
            r_num  <= i_req.dividend;
            r_div  <= i_req.divisor;
            r_cnt  <= i_req.nbits;
            r_quot <= 64'd0;
            r_rem  <= 31'd0;
        end else if (r_busy) begin
            r_num <= {r_num[62:0], 1'b0};
            r_cnt <= r_cnt - 7'd1;
            if (!trial[31]) begin
                r_rem  <= trial[30:0];
                r_quot <= {r_quot[62:0], 1'b1};
            end else begin
                r_rem  <= part[30:0];
                r_quot <= {r_quot[62:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;
endmodule

// ===== sv/complementary_orientation_filter_core.sv =====
// Complementary orientation filter: accelerometer atan2 angles blended with trapezoid
// gyro integration, plus an optional compass heading.
// Usage notes:
// - Input channel i_valid / o_stall: an item is taken when i_valid is high and o_stall
//   low. o_stall stays high from the accepting edge until the item's result has been
//   moved to the output register.
// - Output channel o_valid / i_stall: the result register holds its item until taken.
//   While it waits, the next item may already be accepted and computed; its result is
//   held back until the register is free, and the input stays stalled meanwhile.
// - Configuration i_cfg_valid / o_cfg_ready (always ready): index 0 weight (saturated
//   at 100), 1 ticks per second, 2 compass enable. Write only while idle.
// - Processing: one CORDIC pass per atan2 (three, four with the compass on), then per
//   axis a 64-step bit-serial division by twice the tick rate; the modulo and the blend
//   use the shared multiplier. The first item after reset, or any item taken while all
//   stored angles are zero, skips the division and the modulo.
// - Synchronous reset clears stored angles, previous rates, azimuth, output valid and
//   restores the default configuration.
module complementary_orientation_filter_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_accel_x,
    input  logic signed [31:0] i_accel_y,
    input  logic signed [31:0] i_accel_z,
    input  logic signed [31:0] i_rate_x,
    input  logic signed [31:0] i_rate_y,
    input  logic signed [31:0] i_rate_z,
    input  logic [30:0]        i_elapsed_ticks,
    input  logic signed [31:0] i_field_x,
    input  logic signed [31:0] i_field_y,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [24:0]        o_angle_x_out,
    output logic [24:0]        o_angle_y_out,
    output logic [24:0]        o_angle_z_out,
    output logic signed [24:0] o_north_azimuth,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [29:0]        i_cfg_data
);
    import cof_pkg::*;

    `include "complementary_orientation_filter_core_macros.svh"

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_AGO    = 4'd1;
    localparam logic [3:0] S_AWAIT  = 4'd2;
    localparam logic [3:0] S_GMUL   = 4'd3;
    localparam logic [3:0] S_GADD   = 4'd4;
    localparam logic [3:0] S_DGO    = 4'd5;
    localparam logic [3:0] S_DWAIT  = 4'd6;
    localparam logic [3:0] S_BORDER = 4'd7;
    localparam logic [3:0] S_MULA   = 4'd8;
    localparam logic [3:0] S_MULG   = 4'd9;
    localparam logic [3:0] S_FINISH = 4'd10;
    localparam logic [3:0] S_MODA   = 4'd11;
    localparam logic [3:0] S_MODB   = 4'd12;
    localparam logic [3:0] S_WRAPF  = 4'd13;
    localparam logic [3:0] S_BDIV   = 4'd14;
    localparam logic [3:0] S_BSTORE = 4'd15;

    localparam logic [1:0] CFG_WEIGHT  = 2'd0;
    localparam logic [1:0] CFG_TPS     = 2'd1;
    localparam logic [1:0] CFG_COMPASS = 2'd2;

    // Configuration.
    logic [6:0]  r_weight;
    logic [29:0] r_tps;
    logic        r_cmp_en;

    // Captured item.
    logic signed [31:0] r_acc [3];
    logic signed [31:0] r_rate [3];
    logic [30:0]        r_dt;
    logic signed [31:0] r_fx, r_fy;

    // Filter state.
    t_angle             r_ang [3];
    logic signed [31:0] r_prev [3];
    logic signed [24:0] r_azim;

    // Working registers.
    logic [3:0]         r_state;
    logic [1:0]         r_atn, r_k, r_mc;
    logic               r_seeded;
    t_angle             r_accang [3];
    logic signed [63:0] r_prod, r_sum;
    logic [25:0]        r_a, r_g;
    logic [32:0]        r_blend;
    logic [5:0]         r_mr;
    logic [16:0]        r_mq;

    // Output register.
    logic               r_out_valid;
    t_angle             r_out_x, r_out_y, r_out_z;
    logic signed [24:0] r_out_az;

    // Shared units.
    logic               atn_start, atn_done;
    logic signed [31:0] atn_y, atn_x;
    logic signed [24:0] atn_res;
    t_angle             atn_wrapped;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    logic signed [33:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [65:0] mul_p;
    logic signed [32:0] rate_sum;
    logic [29:0]        tps_eff;
    logic [63:0]        prod_mag, sum_mag;
    logic [47:0]        sum_hi;
    logic [15:0]        mod_chunk;
    logic [21:0]        mod_v, mod_rem;
    logic [24:0]        wrap_rem;
    logic [25:0]        a_adj, g_adj, wrap_g, blend_w;
    logic signed [32:0] acc_ext, acc_mag;
    logic               sat, in_acc, out_load;
    logic [6:0]         cfg_w;

    cof_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (atn_start),
        .i_y     (atn_y),
        .i_x     (atn_x),
        .o_done  (atn_done),
        .o_angle (atn_res)
    );

    cof_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign in_acc    = i_valid && !o_stall;
    assign atn_start = (r_state == S_AGO);
    assign atn_wrapped = t_angle'(atn_res) + (atn_res[24] ? FULL_CIRCLE : 25'd0);

    always_comb begin
        unique case (r_atn)
            2'd0:    begin atn_y = r_acc[1]; atn_x = r_acc[2]; end
            2'd1:    begin atn_y = r_acc[0]; atn_x = r_acc[2]; end
            2'd2:    begin atn_y = r_acc[1]; atn_x = r_acc[0]; end
            default: begin atn_y = r_fy;     atn_x = r_fx;     end
        endcase
    end

    // The one multiplier serves the gyro product, both blend terms, the modulo
    // steps and the blend division.
    assign rate_sum = 33'(r_rate[r_k]) + 33'(r_prev[r_k]);
    always_comb begin
        priority case (r_state)
            S_MULA: begin
                mul_a = 34'({8'd0, r_a});
                mul_b = 32'({25'd0, r_weight});
            end
            S_MULG: begin
                mul_a = 34'({8'd0, r_g});
                mul_b = 32'({25'd0, WEIGHT_MAX - r_weight});
            end
            S_MODA: begin
                mul_a = {12'd0, mod_v};
                mul_b = {9'd0, MOD_RECIP};
            end
            S_BDIV: begin
                mul_a = {2'd0, BLEND_RECIP};
                mul_b = {1'b0, r_blend[32:2]};
            end
            default: begin
                mul_a = 34'(rate_sum);
                mul_b = 32'({1'b0, r_dt});
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign tps_eff  = (r_tps == 30'd0) ? 30'd1 : r_tps;
    assign prod_mag = r_prod[63] ? 64'(-r_prod) : 64'(r_prod);
    assign sum_mag  = r_sum[63] ? 64'(-r_sum) : 64'(r_sum);

    always_comb begin
        div_req.start    = (r_state == S_DGO);
        div_req.dividend = prod_mag;
        div_req.divisor  = {tps_eff, 1'b0};
        div_req.nbits    = 7'd64;
    end

    // The bits above 2^19 are reduced modulo 45 sixteen bits at a time, highest first.
    assign sum_hi = {3'd0, sum_mag[63:19]};
    always_comb begin
        unique case (r_mc)
            2'd0:    mod_chunk = sum_hi[47:32];
            2'd1:    mod_chunk = sum_hi[31:16];
            default: mod_chunk = sum_hi[15:0];
        endcase
    end
    assign mod_v    = {r_mr, mod_chunk};
    assign mod_rem  = mod_v - {5'd0, r_mq} * MOD_DIV;
    assign wrap_rem = {r_mr, sum_mag[18:0]};

    // A negative sum leaves a remainder that is folded back into the circle.
    assign wrap_g = (r_sum[63] && wrap_rem != 25'd0) ?
                    CIRCLE_W - {1'b0, wrap_rem} : {1'b0, wrap_rem};
    assign blend_w = (r_g >= CIRCLE_W) ? r_g - CIRCLE_W : r_g;

    // Border unwrap and the saturated-axis fallback.
    always_comb begin
        a_adj = {1'b0, r_accang[r_k]};
        g_adj = r_g;
        if (r_g > THREE_Q && a_adj < QUARTER) begin
            a_adj = a_adj + CIRCLE_W;
        end
        if (r_g < QUARTER && {1'b0, r_accang[r_k]} > THREE_Q) begin
            g_adj = r_g + CIRCLE_W;
        end
    end
    assign acc_ext = 33'(r_acc[r_k]);
    assign acc_mag = acc_ext[32] ? -acc_ext : acc_ext;
    assign sat     = acc_mag > $signed(ACCEL_LIMIT);

    assign out_load = (r_state == S_FINISH) && (!r_out_valid || !i_stall);
    assign cfg_w    = i_cfg_data[6:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_weight    <= 7'd2;
            r_tps       <= 30'd1000000;
            r_cmp_en    <= 1'b0;
            r_azim      <= 25'sd0;
            r_k         <= 2'd0;
            for (int j = 0; j < 3; j++) begin
                r_ang[j]  <= 25'd0;
                r_prev[j] <= 32'sd0;
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_WEIGHT:  r_weight <= (cfg_w > WEIGHT_MAX) ? WEIGHT_MAX : cfg_w;
                    CFG_TPS:     r_tps    <= i_cfg_data;
                    CFG_COMPASS: r_cmp_en <= i_cfg_data[0];
                    default:     ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_seeded <= (r_ang[0] != 25'd0) || (r_ang[1] != 25'd0) ||
                                    (r_ang[2] != 25'd0);
                        r_atn    <= 2'd0;
                        r_state  <= S_AGO;
                    end
                end
                S_AGO: r_state <= S_AWAIT;
                S_AWAIT: begin
                    if (atn_done) begin
                        if (r_atn == 2'd3) begin
                            r_azim <= atn_res;
                        end else begin
                            r_accang[r_atn] <= atn_wrapped;
                        end
                        if (r_atn == 2'd3 || (r_atn == 2'd2 && !r_cmp_en)) begin
                            r_k     <= 2'd0;
                            r_state <= S_GMUL;
                        end else begin
                            r_atn   <= r_atn + 2'd1;
                            r_state <= S_AGO;
                        end
                    end
                end
                S_GMUL: begin
                    r_prev[r_k] <= r_rate[r_k];
                    if (r_seeded) begin
                        r_prod  <= mul_p[63:0];
                        r_state <= S_DGO;
                    end else begin
                        r_g     <= {1'b0, r_accang[r_k]};
                        r_state <= S_BORDER;
                    end
                end
                S_GADD: begin
                    r_sum   <= r_sum + $signed({39'd0, r_ang[r_k]});
                    r_mc    <= 2'd0;
                    r_mr    <= 6'd0;
                    r_state <= S_MODA;
                end
                S_DGO: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (div_rsp.done) begin
                        r_sum   <= r_prod[63] ? -$signed(div_rsp.quot) :
                                                $signed(div_rsp.quot);
                        r_state <= S_GADD;
                    end
                end
                S_MODA: begin
                    r_mq    <= mul_p[44:28];
                    r_state <= S_MODB;
                end
                S_MODB: begin
                    r_mr <= mod_rem[5:0];
                    if (r_mc == 2'd2) begin
                        r_state <= S_WRAPF;
                    end else begin
                        r_mc    <= r_mc + 2'd1;
                        r_state <= S_MODA;
                    end
                end
                S_WRAPF: begin
                    r_g     <= wrap_g;
                    r_state <= S_BORDER;
                end
                S_BORDER: begin
                    r_a     <= sat ? {1'b0, r_ang[r_k]} : a_adj;
                    r_g     <= g_adj;
                    r_state <= S_MULA;
                end
                S_MULA: begin
                    r_blend <= mul_p[32:0];
                    r_state <= S_MULG;
                end
                S_MULG: begin
                    r_blend <= r_blend + mul_p[32:0];
                    r_state <= S_BDIV;
                end
                S_BDIV: begin
                    r_g     <= mul_p[61:36];
                    r_state <= S_BSTORE;
                end
                S_BSTORE: begin
                    r_ang[r_k] <= blend_w[24:0];
                    if (r_k == 2'd2) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_GMUL;
                    end
                end
                S_FINISH: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end

        if (in_acc) begin
            r_acc[0]  <= i_accel_x;
            r_acc[1]  <= i_accel_y;
            r_acc[2]  <= i_accel_z;
            r_rate[0] <= i_rate_x;
            r_rate[1] <= i_rate_y;
            r_rate[2] <= i_rate_z;
            r_dt      <= i_elapsed_ticks;
            r_fx      <= i_field_x;
            r_fy      <= i_field_y;
        end
        if (out_load) begin
            r_out_x  <= r_ang[0];
            r_out_y  <= r_ang[1];
            r_out_z  <= r_ang[2];
            r_out_az <= r_azim;
        end
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_angle_x_out   = r_out_x;
    assign o_angle_y_out   = r_out_y;
    assign o_angle_z_out   = r_out_z;
    assign o_north_azimuth = r_out_az;
    assign o_cfg_ready     = 1'b1;

    `COF_ASSERT(a_busy_after_accept, (i_valid && !o_stall) |=> o_stall, "item accepted but block not busy")
    `COF_ASSERT(a_angle_range, o_valid |-> (o_angle_x_out < FULL_CIRCLE && o_angle_y_out < FULL_CIRCLE && o_angle_z_out < FULL_CIRCLE), "output angle outside the circle")
    `COF_ASSERT(a_axis_index, r_k != 2'd3, "axis index out of range")
    `COF_ASSERT_NR(a_reset_clears, !i_rst_n |=> !o_valid, "output valid after reset")
endmodule
